### sv/hsr_pkg.sv
// Shared command and status codes for the chained hash set.
package hsr_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_ERASE   = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  localparam int unsigned MAX_READ = 8;
  localparam int unsigned THRESH_RESET = 8;
  localparam logic [2:0] ADDR_THRESH = 3'd0;

endpackage

### sv/hsr_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module hsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/chained_hash_set_rehash.sv
// Top level: chained hash set of pre-hashed keys with doubling rehash.
// Insert shifts the bucket's chain up and writes the key at its head (a full chain
// reports ST_FULL); a split first redistributes every old bucket's keys. Erase scans
// the chain and shifts later keys down; read returns up to MAX_READ keys of one bucket;
// clear/release sweep every table bucket. One item in flight at a time: in_stall stays
// high whenever the sequencer is not idle. Reset: synchronous; a sweep of all table
// buckets then zeroes the chain lengths (one bucket per cycle) while in_stall stays high.
module chained_hash_set_rehash #(
  parameter int unsigned INITIAL_BUCKETS = 16,
  parameter int unsigned MAX_BUCKETS     = 256,
  parameter int unsigned CHAIN_DEPTH     = 8
) (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] key,
  input  logic [7:0]  bucket,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        rehashed,
  output logic [11:0] entry_total,
  output logic [3:0]  chain_length,
  output logic [31:0] key_out,
  output logic        last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned TABLE_BUCKETS =
    (MAX_BUCKETS > INITIAL_BUCKETS) ? MAX_BUCKETS : INITIAL_BUCKETS;
  localparam int unsigned BW  = $clog2(TABLE_BUCKETS);
  localparam int unsigned LW  = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned KD  = TABLE_BUCKETS * CHAIN_DEPTH;
  localparam int unsigned KAW = $clog2(KD);
  localparam int unsigned TW  = $clog2(KD + 1);
  localparam int unsigned PW  = 11;
  localparam logic ADDR_THRESH_BIT = hsr_pkg::ADDR_THRESH[2];

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_SWEEP    = 24'h000002,
    S_INS_LEN  = 24'h000004,
    S_INS_PRB  = 24'h000008,
    S_INS_SHRD = 24'h000010,
    S_INS_SHWR = 24'h000020,
    S_INS_HEAD = 24'h000040,
    S_SP_LEN   = 24'h000080,
    S_SP_LENW  = 24'h000100,
    S_SP_RD    = 24'h000200,
    S_SP_WR    = 24'h000400,
    S_SP_WLO   = 24'h000800,
    S_SP_WHI   = 24'h001000,
    S_ER_LEN   = 24'h002000,
    S_ER_CHK   = 24'h004000,
    S_ER_RD    = 24'h008000,
    S_ER_CMP   = 24'h010000,
    S_ER_SHRD  = 24'h020000,
    S_ER_SHWR  = 24'h040000,
    S_RD_LEN   = 24'h080000,
    S_RD_CHK   = 24'h100000,
    S_RD_RD    = 24'h200000,
    S_RD_OUT   = 24'h400000,
    S_RESP     = 24'h800000
  } state_t;

  state_t state;

  // control state
  logic [9:0]    threshold;
  logic [BW-1:0] mask;
  logic          ready;
  logic [PW-1:0] probe;
  logic [TW-1:0] key_total;
  logic          from_reset;
  logic          split_done;
  logic [BW-1:0] sidx;
  logic [BW-1:0] sb;

  // item context
  logic [31:0]   key_r;
  logic [7:0]    bucket_r;
  logic [BW-1:0] cb;
  logic [LW-1:0] len_r;
  logic [LW-1:0] nread;
  logic [LW-1:0] idx;
  logic [LW-1:0] lo;
  logic [LW-1:0] hi;
  logic [1:0]    res_status;
  logic          res_rehashed;

  // memory ports
  logic           k_we, k_re, c_we, c_re;
  logic [KAW-1:0] k_waddr, k_raddr;
  logic [31:0]    k_wdata, k_rdata;
  logic [BW-1:0]  c_waddr, c_raddr;
  logic [LW-1:0]  c_wdata, c_rdata;

  logic            accept, out_free, out_load;
  logic [BW-1:0]   kb, rb, old_bw;
  logic [BW:0]     mask_cnt;
  logic [PW-1:0]   psum;
  logic            idx_last;
  logic            rd_last;

  function automatic logic [KAW-1:0] kaddr(input logic [BW-1:0] b, input logic [LW-1:0] i);
    kaddr = KAW'(b) * KAW'(CHAIN_DEPTH) + KAW'(i);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // result register loads this cycle
  assign out_load = ((state == S_RESP) || (state == S_RD_OUT)) && out_free;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == ADDR_THRESH_BIT) ? {22'd0, threshold} : 32'd0;

  assign kb       = BW'(key_r) & mask;
  assign rb       = BW'(bucket_r);
  assign mask_cnt = {1'b0, mask} + (BW+1)'(1);
  assign old_bw   = BW'(mask_cnt);
  // saturating decay, then add the target chain length
  assign psum     = ((probe > PW'(3)) ? (probe - PW'(3)) : PW'(0)) + PW'(c_rdata);
  assign idx_last = ((LW+1)'(idx) + (LW+1)'(1)) == (LW+1)'(len_r);
  assign rd_last  = ((LW+1)'(idx) + (LW+1)'(1)) == (LW+1)'(nread);

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 10'(hsr_pkg::THRESH_RESET);
    end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_THRESH_BIT)) begin
      threshold <= pwdata[9:0];
    end
  end

  // memory control
  always_comb begin
    k_we = 1'b0; k_waddr = '0; k_wdata = '0;
    k_re = 1'b0; k_raddr = '0;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0;
    c_re = 1'b0; c_raddr = '0;
    unique case (state)
      S_SWEEP: begin
        c_we = 1'b1; c_waddr = sidx;
      end
      S_INS_LEN: begin
        c_re = 1'b1; c_raddr = kb;
      end
      S_INS_SHRD: begin
        k_re = 1'b1; k_raddr = kaddr(cb, idx - LW'(1));
      end
      S_INS_SHWR: begin
        k_we = 1'b1; k_waddr = kaddr(cb, idx); k_wdata = k_rdata;
      end
      S_INS_HEAD: begin
        k_we = 1'b1; k_waddr = kaddr(cb, '0); k_wdata = key_r;
        c_we = 1'b1; c_waddr = cb; c_wdata = len_r + LW'(1);
      end
      S_SP_LEN: begin
        c_re = 1'b1; c_raddr = sb;
      end
      S_SP_RD: begin
        k_re = 1'b1; k_raddr = kaddr(sb, idx);
      end
      S_SP_WR: begin
        k_we = 1'b1; k_wdata = k_rdata;
        if ((k_rdata & 32'(mask_cnt)) != 32'd0) begin
          k_waddr = kaddr(sb + old_bw, hi);
        end else begin
          k_waddr = kaddr(sb, lo);
        end
      end
      S_SP_WLO: begin
        c_we = 1'b1; c_waddr = sb; c_wdata = lo;
      end
      S_SP_WHI: begin
        c_we = 1'b1; c_waddr = sb + old_bw; c_wdata = hi;
      end
      S_ER_LEN: begin
        c_re = ready; c_raddr = kb;
      end
      S_ER_RD: begin
        k_re = 1'b1; k_raddr = kaddr(cb, idx);
      end
      S_ER_SHRD: begin
        if (idx_last) begin
          c_we = 1'b1; c_waddr = cb; c_wdata = len_r - LW'(1);
        end else begin
          k_re = 1'b1; k_raddr = kaddr(cb, idx + LW'(1));
        end
      end
      S_ER_SHWR: begin
        k_we = 1'b1; k_waddr = kaddr(cb, idx); k_wdata = k_rdata;
      end
      S_RD_LEN: begin
        c_re = 1'b1; c_raddr = rb;
      end
      S_RD_RD: begin
        k_re = 1'b1; k_raddr = kaddr(rb, idx);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sidx       <= '0;
      from_reset <= 1'b1;
      mask       <= BW'(INITIAL_BUCKETS - 1);
      ready      <= 1'b0;
      probe      <= '0;
      key_total  <= '0;
      out_valid  <= 1'b0;
      split_done <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key_r        <= key;
            bucket_r     <= bucket;
            res_status   <= hsr_pkg::ST_OK;
            res_rehashed <= 1'b0;
            split_done   <= 1'b0;
            priority case (command)
              hsr_pkg::CMD_INSERT: begin
                // bring the table up on first use; chains are already zero
                if (!ready) begin
                  ready     <= 1'b1;
                  probe     <= '0;
                  key_total <= '0;
                end
                state <= S_INS_LEN;
              end
              hsr_pkg::CMD_ERASE: state <= S_ER_LEN;
              hsr_pkg::CMD_CLEAR, hsr_pkg::CMD_RELEASE: begin
                probe      <= '0;
                key_total  <= '0;
                sidx       <= '0;
                from_reset <= 1'b0;
                if (command == hsr_pkg::CMD_RELEASE) begin
                  ready <= 1'b0;
                  mask  <= BW'(INITIAL_BUCKETS - 1);
                end
                state <= S_SWEEP;
              end
              hsr_pkg::CMD_READ: state <= S_RD_LEN;
              default: state <= S_RESP;
            endcase
          end
        end
        S_SWEEP: begin
          sidx <= sidx + BW'(1);
          if (sidx == BW'(TABLE_BUCKETS - 1)) begin
            state <= from_reset ? S_IDLE : S_RESP;
          end
        end
        S_INS_LEN: begin
          cb    <= kb;
          state <= S_INS_PRB;
        end
        S_INS_PRB: begin
          if (!split_done && (mask_cnt < (BW+1)'(MAX_BUCKETS)) && (psum > PW'(threshold))) begin
            probe        <= '0;
            res_rehashed <= 1'b1;
            split_done   <= 1'b1;
            sb           <= '0;
            state        <= S_SP_LEN;
          end else begin
            if (!split_done && (mask_cnt < (BW+1)'(MAX_BUCKETS))) begin
              probe <= psum;
            end
            if ((LW+1)'(c_rdata) >= (LW+1)'(CHAIN_DEPTH)) begin
              res_status <= hsr_pkg::ST_FULL;
              state      <= S_RESP;
            end else begin
              len_r <= c_rdata;
              idx   <= c_rdata;
              state <= S_INS_SHRD;
            end
          end
        end
        S_INS_SHRD: begin
          state <= (idx == '0) ? S_INS_HEAD : S_INS_SHWR;
        end
        S_INS_SHWR: begin
          idx   <= idx - LW'(1);
          state <= S_INS_SHRD;
        end
        S_INS_HEAD: begin
          key_total <= key_total + TW'(1);
          state     <= S_RESP;
        end
        S_SP_LEN: state <= S_SP_LENW;
        S_SP_LENW: begin
          len_r <= c_rdata;
          idx   <= '0;
          lo    <= '0;
          hi    <= '0;
          state <= (c_rdata == '0) ? S_SP_WLO : S_SP_RD;
        end
        S_SP_RD: state <= S_SP_WR;
        S_SP_WR: begin
          if ((k_rdata & 32'(mask_cnt)) != 32'd0) begin
            hi <= hi + LW'(1);
          end else begin
            lo <= lo + LW'(1);
          end
          idx   <= idx + LW'(1);
          state <= idx_last ? S_SP_WLO : S_SP_RD;
        end
        S_SP_WLO: state <= S_SP_WHI;
        S_SP_WHI: begin
          if (sb == old_bw - BW'(1)) begin
            mask  <= {mask[BW-2:0], 1'b1};
            state <= S_INS_LEN;
          end else begin
            sb    <= sb + BW'(1);
            state <= S_SP_LEN;
          end
        end
        S_ER_LEN: begin
          cb <= kb;
          if (!ready) begin
            res_status <= hsr_pkg::ST_NOT_FOUND;
            state      <= S_RESP;
          end else begin
            state <= S_ER_CHK;
          end
        end
        S_ER_CHK: begin
          len_r <= c_rdata;
          idx   <= '0;
          if (c_rdata == '0) begin
            res_status <= hsr_pkg::ST_NOT_FOUND;
            state      <= S_RESP;
          end else begin
            state <= S_ER_RD;
          end
        end
        S_ER_RD: state <= S_ER_CMP;
        S_ER_CMP: begin
          if (k_rdata == key_r) begin
            state <= S_ER_SHRD;
          end else if (idx_last) begin
            res_status <= hsr_pkg::ST_NOT_FOUND;
            state      <= S_RESP;
          end else begin
            idx   <= idx + LW'(1);
            state <= S_ER_RD;
          end
        end
        S_ER_SHRD: begin
          if (idx_last) begin
            key_total <= key_total - TW'(1);
            state     <= S_RESP;
          end else begin
            state <= S_ER_SHWR;
          end
        end
        S_ER_SHWR: begin
          idx   <= idx + LW'(1);
          state <= S_ER_SHRD;
        end
        S_RD_LEN: begin
          if (!ready || (32'(bucket_r) > 32'(mask))) begin
            res_status <= hsr_pkg::ST_EMPTY;
            state      <= S_RESP;
          end else begin
            state <= S_RD_CHK;
          end
        end
        S_RD_CHK: begin
          len_r <= c_rdata;
          nread <= (32'(c_rdata) > 32'(hsr_pkg::MAX_READ)) ? LW'(hsr_pkg::MAX_READ) : c_rdata;
          idx   <= '0;
          if (c_rdata == '0) begin
            res_status <= hsr_pkg::ST_EMPTY;
            state      <= S_RESP;
          end else begin
            state <= S_RD_RD;
          end
        end
        S_RD_RD: state <= S_RD_OUT;
        S_RD_OUT: begin
          // key RAM output holds until the result register frees up
          if (out_free) begin
            status       <= hsr_pkg::ST_OK;
            rehashed     <= 1'b0;
            entry_total  <= 12'(key_total);
            chain_length <= 4'(len_r);
            key_out      <= k_rdata;
            last         <= rd_last;
            idx          <= idx + LW'(1);
            state        <= rd_last ? S_IDLE : S_RD_RD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            status       <= res_status;
            rehashed     <= res_rehashed;
            entry_total  <= 12'(key_total);
            chain_length <= 4'd0;
            key_out      <= 32'd0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  hsr_ram #(.WIDTH(32), .DEPTH(KD)) u_keys (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  hsr_ram #(.WIDTH(LW), .DEPTH(TABLE_BUCKETS)) u_lens (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

`ifndef SYNTHESIS
  a_mask_pow2: assert property (@(posedge clk) disable iff (rst) $onehot(mask_cnt))
    else $error("bucket mask not contiguous");
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    32'(key_total) <= 32'(KD))
    else $error("key total beyond table capacity");
  a_one_item: assert property (@(posedge clk) disable iff (rst) accept |=> in_stall)
    else $error("second transfer taken while busy");
  a_split_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SP_WHI) |-> (32'(sb) < 32'(mask_cnt)))
    else $error("split walked past old bucket count");
  a_resp_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_free) |=> (out_valid && last))
    else $error("single result not presented");
`endif

endmodule
